FILE: rtl/tgnf_pkg.sv
// ----------------------------------------------------------------------------
// tgnf_pkg: shared types and constants for the tileable gradient noise block.
// Holds the payload words, configuration indexes and the fixed constants.
// ----------------------------------------------------------------------------
package tgnf_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int MAX_OCTAVES_DEF     = 8;

  localparam logic [31:0] HASH_K0 = 32'd1597334673;
  localparam logic [31:0] HASH_K1 = 32'd3812015801;
  localparam logic [31:0] HASH_K2 = 32'd2798796415;
  localparam logic [15:0] GAIN_Q16 = 16'd36358;

  localparam logic [0:0] CFG_BASE_FREQ    = 1'b0;
  localparam logic [0:0] CFG_OCTAVE_COUNT = 1'b1;

  typedef struct packed {
    logic [15:0] coord_x;
    logic [15:0] coord_y;
    logic [15:0] coord_z;
  } in_word_t;

  typedef struct packed {
    logic signed [20:0] noise_value;
    logic [7:0]         billow_byte;
    logic               saturated;
  } out_word_t;

endpackage

FILE: rtl/tgnf_octave.sv
// ----------------------------------------------------------------------------
// tgnf_octave: one octave of tileable gradient noise, pipelined.
// Stage 1 cell/fraction, stages 2-4 fade powers, hash and gradients, stage 5
// fade and dot products, stages 6-8 the three lerps. Output is the octave
// value in Q.32, registered in stage 8.
// ----------------------------------------------------------------------------
module tgnf_octave #(
  parameter int COORD_FRAC_BITS = tgnf_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [15:0]        cx,
  input  logic [15:0]        cy,
  input  logic [15:0]        cz,
  input  logic [20:0]        freq,
  output logic               out_valid,
  output logic signed [36:0] value
);

  localparam int FB = COORD_FRAC_BITS;
  localparam int NS = 8;
  localparam int PW = (FB + 21 > 37) ? FB + 21 : 37;
  localparam logic [15:0] CMASK = 16'((64'd1 << FB) - 64'd1);

  logic [NS-1:0] vld;

  // Stage 1: lattice position.
  logic [2:0][20:0] ci1, cn1;
  logic [2:0][16:0] w1;
  logic [2:0][15:0] cin;
  assign cin = {cz, cy, cx};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic [PW-1:0] p;
        logic [20:0] c0;
        logic [20:0] c1;
        p  = PW'(cin[k] & CMASK) * PW'(freq);
        c0 = p[FB+20:FB];
        c1 = c0 + 21'd1;
        ci1[k] <= c0;
        cn1[k] <= (c1 >= freq) ? 21'd0 : c1;
        w1[k]  <= 17'((PW'(p[FB-1:0]) << 16) >> FB);
      end
    end
  end

  // Stage 2: w2 and the per-axis hash products of both cells.
  logic [2:0][16:0] w2s, w2w;
  logic [2:0][31:0] h0, h1;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic [31:0] hk;
        logic [33:0] sq;
        hk = (k == 0) ? tgnf_pkg::HASH_K0 : (k == 1) ? tgnf_pkg::HASH_K1 :
             tgnf_pkg::HASH_K2;
        sq = w1[k] * w1[k];
        w2s[k] <= 17'(sq >> 16);
        w2w[k] <= w1[k];
        h0[k]  <= 32'({11'd0, ci1[k]} * hk);
        h1[k]  <= 32'({11'd0, cn1[k]} * hk);
      end
    end
  end

  // Stage 3: w3; corner hash words n.
  logic [2:0][16:0] w3s, w3w;
  logic [7:0][31:0] n3;
  logic [2:0][16:0] w3keep;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic [33:0] t;
        t = w2s[k] * w2w[k];
        w3s[k] <= 17'(t >> 16);
        w3w[k] <= w2w[k];
      end
      for (int b = 0; b < 8; b++) begin
        n3[b] <= (b[0] ? h1[0] : h0[0]) ^ (b[1] ? h1[1] : h0[1]) ^
                 (b[2] ? h1[2] : h0[2]);
      end
    end
  end
  assign w3keep = w3w;

  // Stage 4: w4; gradient components.
  logic [2:0][16:0] w4s, w4w, w4c;
  logic [7:0][2:0][17:0] g4;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic [33:0] t;
        t = w3s[k] * w3keep[k];
        w4s[k] <= 17'(t >> 16);
        w4w[k] <= w3keep[k];
        w4c[k] <= w3s[k];
      end
      for (int b = 0; b < 8; b++) begin
        logic [31:0] m0, m1, m2;
        m0 = 32'(n3[b] * tgnf_pkg::HASH_K0);
        m1 = 32'(n3[b] * tgnf_pkg::HASH_K1);
        m2 = 32'(n3[b] * tgnf_pkg::HASH_K2);
        g4[b][0] <= 18'({1'b0, m0[31:15]}) - 18'sd65536;
        g4[b][1] <= 18'({1'b0, m1[31:15]}) - 18'sd65536;
        g4[b][2] <= 18'({1'b0, m2[31:15]}) - 18'sd65536;
      end
    end
  end

  // Stage 5: w5 and fade; dot products.
  logic [2:0][16:0] u5;
  logic signed [35:0] v5 [8];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic [33:0] t;
        logic [16:0] w5;
        logic signed [22:0] uu;
        t  = w4s[k] * w4w[k];
        w5 = 17'(t >> 16);
        uu = 23'sd6 * $signed({6'd0, w5}) - 23'sd15 * $signed({6'd0, w4s[k]})
           + 23'sd10 * $signed({6'd0, w4c[k]});
        u5[k] <= (uu < 0) ? 17'd0 : (uu > 23'sd65536) ? 17'd65536 : uu[16:0];
      end
      for (int b = 0; b < 8; b++) begin
        logic signed [35:0] acc;
        acc = '0;
        for (int k = 0; k < 3; k++) begin
          logic signed [17:0] d;
          d = $signed({1'b0, w4w[k]}) - (b[k] ? 18'sd65536 : 18'sd0);
          acc = acc + 36'($signed(g4[b][k])) * 36'(d);
        end
        v5[b] <= acc;
      end
    end
  end

  function automatic logic signed [36:0] lerp(input logic signed [36:0] a,
                                              input logic signed [36:0] b,
                                              input logic [16:0] u);
    logic signed [55:0] pr;
    pr = (b - a) * $signed({1'b0, u});
    return a + 37'(pr >>> 16);
  endfunction

  // Stages 6-8: lerps along x, y, z.
  logic signed [36:0] l6 [4];
  logic signed [36:0] l7 [2];
  logic [1:0][16:0] u6;
  logic [16:0] u7;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int b = 0; b < 4; b++)
        l6[b] <= lerp(37'(v5[2*b]), 37'(v5[2*b+1]), u5[0]);
      u6 <= {u5[2], u5[1]};
      for (int b = 0; b < 2; b++)
        l7[b] <= lerp(l6[2*b], l6[2*b+1], u6[0]);
      u7 <= u6[1];
      value <= lerp(l7[0], l7[1], u7);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end
  assign out_valid = vld[NS-1];

endmodule

FILE: rtl/tileable_gradient_noise_fbm.sv
// ----------------------------------------------------------------------------
// tileable_gradient_noise_fbm: fractal sum of tileable gradient noise.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_ready | in_word_t coordinates
//  result  | output    | out_valid/out_ready | out_word_t sum, billow, flag
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// MAX_OCTAVES octave datapaths are chained, one per octave, so one word
// enters per cycle while the output is not stalled; each octave is its datapath
// plus a register to weight and add, and the clamp and billow stages follow.
// Reset clears the valid bits and loads base_freq 4, octave_count 7.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module tileable_gradient_noise_fbm #(
  parameter int COORD_FRAC_BITS = tgnf_pkg::COORD_FRAC_BITS_DEF,
  parameter int MAX_OCTAVES     = tgnf_pkg::MAX_OCTAVES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tgnf_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tgnf_pkg::out_word_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [0:0]           cfg_index,
  input  logic [8:0]           cfg_data
);

  localparam int OL = 8;  // octave datapath latency

  logic [8:0] base_freq;
  logic [3:0] octave_count;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      base_freq <= 9'd4;
      octave_count <= 4'd7;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tgnf_pkg::CFG_BASE_FREQ:    base_freq <= cfg_data;
        tgnf_pkg::CFG_OCTAVE_COUNT: octave_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic [8:0] f0;
  logic [3:0] cnt;
  assign f0 = (base_freq == 9'd0) ? 9'd1 : (base_freq > 9'd256) ? 9'd256 : base_freq;
  assign cnt = (octave_count > 4'(MAX_OCTAVES)) ? 4'(MAX_OCTAVES) : octave_count;

  logic en;
  logic fin_valid;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // Per-octave chain: each stage carries coords, running sum, amplitude.
  logic               cv [0:MAX_OCTAVES];
  logic [47:0]        cc [0:MAX_OCTAVES];
  logic signed [27:0] cs [0:MAX_OCTAVES];
  logic [16:0]        ca [0:MAX_OCTAVES];
  assign cv[0] = in_valid && in_ready;
  assign cc[0] = in_data;
  assign cs[0] = '0;
  assign ca[0] = 17'd65536;

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    logic [OL-1:0][47:0] dc;
    logic signed [OL-1:0][27:0] ds;
    logic [OL-1:0][16:0] da;
    logic ov;
    logic signed [36:0] val;
    tgnf_octave #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_oct (
      .clk(clk), .rst(rst), .en(en), .in_valid(cv[i]),
      .cx(cc[i][47:32]), .cy(cc[i][31:16]), .cz(cc[i][15:0]),
      .freq(21'(f0) << i), .out_valid(ov), .value(val)
    );
    always_ff @(posedge clk) begin
      if (en) begin
        dc[0] <= cc[i]; ds[0] <= cs[i]; da[0] <= ca[i];
        for (int s = 1; s < OL; s++) begin
          dc[s] <= dc[s-1]; ds[s] <= ds[s-1]; da[s] <= da[s-1];
        end
      end
    end
    // Weight by amplitude: floor(value*amp / 2^32).
    logic signed [54:0] pr;
    assign pr = val * $signed({1'b0, da[OL-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        cs[i+1] <= ds[OL-1] + ((4'(i) < cnt) ? 28'(pr >>> 32) : 28'sd0);
        ca[i+1] <= 17'((34'(da[OL-1]) * 34'(tgnf_pkg::GAIN_Q16)) >> 16);
        cc[i+1] <= dc[OL-1];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) cv[i+1] <= 1'b0;
      else if (en) cv[i+1] <= ov;
    end
  end

  // Clamp stage, then billow stage.
  logic signed [20:0] sum_c;
  logic sat_c, v1;
  always_ff @(posedge clk) begin
    if (en) begin
      sat_c <= (cs[MAX_OCTAVES] > 28'sd1048575) || (cs[MAX_OCTAVES] < -28'sd1048576);
      sum_c <= (cs[MAX_OCTAVES] > 28'sd1048575) ? 21'sd1048575 :
               (cs[MAX_OCTAVES] < -28'sd1048576) ? -21'sd1048576 : 21'(cs[MAX_OCTAVES]);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= cv[MAX_OCTAVES];
  end
  assign fin_valid = v1;

  always_ff @(posedge clk) begin
    if (en) begin
      logic [20:0] mag;
      logic [28:0] bl;
      mag = sum_c[20] ? 21'(-sum_c) : sum_c;
      bl = (29'(mag) * 29'd255) >> 16;
      out_data.noise_value <= sum_c;
      out_data.saturated <= sat_c;
      out_data.billow_byte <= (bl > 29'd255) ? 8'd255 : bl[7:0];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= fin_valid;
  end

`ifndef SYNTHESIS
  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |->
      (out_data.noise_value == 21'sd1048575 || out_data.noise_value == -21'sd1048576))
    else $error("sat");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("hold");
`endif

endmodule
